/* sv/clrr_pkg.sv */
package clrr_pkg;

    localparam int MAX_CENTROIDS = 16;
    localparam int ID_W          = $clog2(MAX_CENTROIDS);
    localparam int CNT_W         = $clog2(MAX_CENTROIDS + 1);
    localparam int KEY_W         = 32;
    localparam int CFG_W         = 5;
    localparam int LABEL_W       = 4;
    localparam int RES_W         = 4;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;

    localparam logic [CFG_W-1:0] NUM_CENTROIDS_RESET = CFG_W'(4);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_EMIT  = 2'd1,
        OP_MAP   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_LABEL = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    localparam logic REG_NUM_CENTROIDS = 1'b0;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [ID_W-1:0]         id;
    } entry_t;

    typedef struct packed {
        logic            ins_en;
        logic            live;
        logic [ID_W-1:0] label;
    } cell_ctrl_t;

endpackage

/* sv/clrr_cell.sv */
module clrr_cell (
    input  logic                aclk,
    input  clrr_pkg::cell_ctrl_t ctrl,
    input  clrr_pkg::entry_t    new_entry,
    input  clrr_pkg::entry_t    prev_entry,
    input  logic                prev_gt,
    output clrr_pkg::entry_t    entry,
    output logic                gt,
    output logic                match
);
    import clrr_pkg::*;

    entry_t entry_reg;

    // An empty slot counts as greater than any key, so the new key
    // lands at the first slot holding a strictly greater key.
    assign gt    = !ctrl.live || (entry_reg.key > new_entry.key);
    assign match = ctrl.live && (entry_reg.id == ctrl.label);
    assign entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && gt) begin
            if (prev_gt) begin
                entry_reg <= prev_entry;
            end else begin
                entry_reg <= new_entry;
            end
        end
    end

endmodule

/* sv/cluster_label_rank_remap_core.sv */
// Channel  Ports                                               Direction
// s_       s_valid s_ready s_opcode s_centroid_key s_point_label  word in
// m_       m_valid m_ready m_result_value m_status m_last_flag    word out
// apb      psel penable pwrite paddr pwdata prdata pready         config
//
// Load, map and clear leave the block idle; a load inserts its key into the
// row of cells when it is accepted and a map finds the rank by matching all cells.
// Emit then holds off the input while it reads each loaded centroid from
// the cells by index, and also while m_ready is low.
// Reset is synchronous; it empties the set and sets num_centroids to 4.
// A word waiting in the output register holds off the input until it is taken.
module cluster_label_rank_remap_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [clrr_pkg::KEY_W-1:0] s_centroid_key,
    input  logic [clrr_pkg::LABEL_W-1:0]      s_point_label,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [clrr_pkg::RES_W-1:0]        m_result_value,
    output logic [1:0]                        m_status,
    output logic                              m_last_flag,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clrr_pkg::ADDR_W-1:0]       paddr,
    input  logic [clrr_pkg::DATA_W-1:0]       pwdata,
    output logic [clrr_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    import clrr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   idx_reg, idx_next;
    logic [CFG_W-1:0]  num_reg;
    logic              m_valid_reg, m_valid_next;
    logic [RES_W-1:0]  value_reg, value_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;

    logic              accept, out_free, full, ins_en, label_ok, emit_last;
    logic [CNT_W-1:0]  active;
    logic [ID_W-1:0]   rank;
    entry_t            new_entry;
    entry_t            cell_q [MAX_CENTROIDS];
    logic              cell_gt [MAX_CENTROIDS];
    logic              cell_match [MAX_CENTROIDS];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_CENTROIDS) ? DATA_W'(num_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= NUM_CENTROIDS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_NUM_CENTROIDS) begin
            num_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (num_reg == '0) begin
            active = CNT_W'(1);
        end else if (int'(num_reg) > MAX_CENTROIDS) begin
            active = CNT_W'(MAX_CENTROIDS);
        end else begin
            active = CNT_W'(num_reg);
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign full      = count_reg >= active;
    assign ins_en    = accept && (opcode_t'(s_opcode) == OP_LOAD) && !full;
    assign label_ok  = int'(s_point_label) < int'(count_reg);
    assign emit_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    assign new_entry = {s_centroid_key, count_reg[ID_W-1:0]};

    for (genvar i = 0; i < MAX_CENTROIDS; i++) begin : g_cell
        cell_ctrl_t ctrl;
        assign ctrl = {ins_en, (CNT_W'(i) < count_reg), ID_W'(s_point_label)};
        if (i == 0) begin : g_head
            clrr_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (new_entry),
                .prev_gt    (1'b0),
                .entry      (cell_q[i]),
                .gt         (cell_gt[i]),
                .match      (cell_match[i])
            );
        end else begin : g_body
            clrr_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (cell_q[i-1]),
                .prev_gt    (cell_gt[i-1]),
                .entry      (cell_q[i]),
                .gt         (cell_gt[i]),
                .match      (cell_match[i])
            );
        end
    end

    always_comb begin
        rank = '0;
        for (int i = 0; i < MAX_CENTROIDS; i++) begin
            if (cell_match[i]) begin
                rank = rank | ID_W'(i);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (opcode_t'(s_opcode))
                        OP_LOAD: begin
                            m_valid_next = 1'b1;
                            value_next   = '0;
                            last_next    = 1'b1;
                            status_next  = full ? STAT_FULL : STAT_OK;
                            if (!full) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_EMIT: begin
                            if (count_reg != '0) begin
                                state_next = ST_EMIT;
                                idx_next   = '0;
                            end
                        end
                        OP_MAP: begin
                            m_valid_next = 1'b1;
                            last_next    = 1'b1;
                            status_next  = label_ok ? STAT_OK : STAT_BAD_LABEL;
                            value_next   = label_ok ? RES_W'(rank) : '0;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    value_next   = RES_W'(cell_q[idx_reg].id);
                    status_next  = STAT_OK;
                    last_next    = emit_last;
                    idx_next     = idx_reg + ID_W'(1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = value_reg;
    assign m_status       = status_reg;
    assign m_last_flag    = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= MAX_CENTROIDS)
        else $error("Loaded key count exceeds capacity.");

    a_emit_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("Emit index ran past the loaded keys.");

    a_emit_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !s_ready)
        else $error("Input taken during an emit run.");

    a_load_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("Accepted load did not advance the key count.");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && opcode_t'(s_opcode) == OP_LOAD && full) |=>
        (m_valid_reg && status_reg == STAT_FULL && count_reg == $past(count_reg)))
        else $error("Load into a full set was not refused.");

endmodule

/* bench/testbench.sv */
module testbench;
    import clrr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 250;
    localparam logic [ADDR_W-1:0] COUNT_ADDR = ADDR_W'(4 * int'(REG_NUM_CENTROIDS));
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * (int'(REG_NUM_CENTROIDS) + 1));

    typedef struct {
        logic [RES_W-1:0] value;
        status_t          status;
        logic             last;
    } rank_word_t;

    // Tracks the sorted key row and the rank table, and holds the words still due.
    class rank_remap_board;
        logic signed [KEY_W-1:0] key_row[MAX_CENTROIDS];
        logic [ID_W-1:0]         id_row[MAX_CENTROIDS];
        logic [ID_W-1:0]         rank_of[MAX_CENTROIDS];
        int                      loaded;
        logic [CFG_W-1:0]        count_reg;
        rank_word_t              due_words[$];
        int                      errors;

        function new();
            loaded    = 0;
            count_reg = NUM_CENTROIDS_RESET;
            errors    = 0;
        endfunction

        function int active_count();
            int n;
            n = int'(count_reg);
            if (n < 1) begin
                n = 1;
            end
            if (n > MAX_CENTROIDS) begin
                n = MAX_CENTROIDS;
            end
            return n;
        endfunction

        function void push_word(logic [RES_W-1:0] value, status_t status, logic last);
            rank_word_t w;
            w.value  = value;
            w.status = status;
            w.last   = last;
            due_words.push_back(w);
        endfunction

        // Equal keys stay behind the ones loaded earlier.
        function void place_key(logic signed [KEY_W-1:0] key);
            int pos;
            pos = loaded;
            while (pos > 0 && key_row[pos-1] > key) begin
                key_row[pos] = key_row[pos-1];
                id_row[pos]  = id_row[pos-1];
                pos--;
            end
            key_row[pos] = key;
            id_row[pos]  = ID_W'(loaded);
            loaded++;
            for (int i = 0; i < loaded; i++) begin
                rank_of[id_row[i]] = ID_W'(i);
            end
        endfunction

        function void take_word(opcode_t op, logic signed [KEY_W-1:0] key,
                                logic [LABEL_W-1:0] label);
            case (op)
                OP_LOAD: begin
                    if (loaded >= active_count()) begin
                        push_word('0, STAT_FULL, 1'b1);
                    end else begin
                        place_key(key);
                        push_word('0, STAT_OK, 1'b1);
                    end
                end
                OP_EMIT: begin
                    for (int i = 0; i < loaded; i++) begin
                        push_word(RES_W'(id_row[i]), STAT_OK, (i + 1 == loaded));
                    end
                end
                OP_MAP: begin
                    if (int'(label) >= loaded) begin
                        push_word('0, STAT_BAD_LABEL, 1'b1);
                    end else begin
                        push_word(RES_W'(rank_of[label]), STAT_OK, 1'b1);
                    end
                end
                default: begin
                    loaded = 0;
                end
            endcase
        endfunction

        function void check_word(logic [RES_W-1:0] value, logic [1:0] status, logic last);
            rank_word_t w;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: word with none due: value %0d status %0d last %0d",
                         $time, value, status, last);
                return;
            end
            w = due_words.pop_front();
            if (value !== w.value) begin
                errors++;
                $display("%0t: result_value expected %0d actual %0d", $time, w.value, value);
            end
            if (status !== w.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, w.status, status);
            end
            if (last !== w.last) begin
                errors++;
                $display("%0t: last_flag expected %0d actual %0d", $time, w.last, last);
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_opcode       = 2'd0;
    logic signed [KEY_W-1:0]  s_centroid_key = '0;
    logic [LABEL_W-1:0]       s_point_label  = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [RES_W-1:0]         m_result_value;
    logic [1:0]               m_status;
    logic                     m_last_flag;
    logic                     psel           = 1'b0;
    logic                     penable        = 1'b0;
    logic                     pwrite         = 1'b0;
    logic [ADDR_W-1:0]        paddr          = '0;
    logic [DATA_W-1:0]        pwdata         = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    rank_remap_board remap_board = new();
    int idle_pct   = 0;
    int stall_pct  = 0;
    int words_sent = 0;
    int cycles     = 0;

    cluster_label_rank_remap_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_centroid_key (s_centroid_key),
        .s_point_label  (s_point_label),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_last_flag    (m_last_flag),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                remap_board.take_word(opcode_t'(s_opcode), s_centroid_key, s_point_label);
            end
            if (m_valid && m_ready) begin
                remap_board.check_word(m_result_value, m_status, m_last_flag);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d words due", $time, remap_board.due_words.size());
            $display("cluster_label_rank_remap_core test failed");
            $finish;
        end
    end

    task automatic send_word(opcode_t op, logic signed [KEY_W-1:0] key,
                             logic [LABEL_W-1:0] label);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid        <= 1'b0;
            s_opcode       <= 2'($urandom);
            s_centroid_key <= $urandom;
            s_point_label  <= LABEL_W'($urandom);
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_centroid_key <= key;
        s_point_label  <= label;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        words_sent++;
    endtask

    // A clear or an empty emit leaves no word to wait on, so the block gets extra cycles.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (remap_board.due_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(DATA_W - CFG_W)'($urandom_range(0, (1 << (DATA_W - CFG_W)) - 1)),
                    value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == COUNT_ADDR) begin
            remap_board.count_reg = value;
        end
        @(posedge aclk);
    endtask

    task automatic read_count();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= COUNT_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== DATA_W'(remap_board.count_reg)) begin
            remap_board.errors++;
            $display("%0t: num_centroids read expected %0d actual %0d",
                     $time, remap_board.count_reg, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_count(logic [CFG_W-1:0] value);
        drain();
        write_reg(COUNT_ADDR, value);
        read_count();
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(int mode);
        logic signed [KEY_W-1:0] k;
        case (mode)
            0: k = $urandom;
            1: k = KEY_W'(signed'($urandom_range(0, 4)) - 2) <<< 16;
            default: begin
                case ($urandom_range(0, 3))
                    0: k = {1'b1, {(KEY_W-1){1'b0}}};
                    1: k = {1'b0, {(KEY_W-1){1'b1}}};
                    2: k = '0;
                    default: k = '1;
                endcase
            end
        endcase
        return k;
    endfunction

    initial begin
        int cfg_list[6];
        int session;
        int loads;
        int kmode;
        int maps;
        int live;
        cfg_list = '{16, 1, 0, 31, 17, 5};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(OP_EMIT, '0, '0);
        send_word(OP_MAP, '0, '0);
        send_word(OP_LOAD, {1'b0, {(KEY_W-1){1'b1}}}, '0);
        send_word(OP_LOAD, {1'b1, {(KEY_W-1){1'b0}}}, '0);
        send_word(OP_LOAD, '0, '0);
        send_word(OP_LOAD, '0, '1);
        send_word(OP_LOAD, 32'sd5, '0);
        send_word(OP_EMIT, '0, '0);
        for (int i = 0; i < 4; i++) begin
            send_word(OP_MAP, $urandom, LABEL_W'(i));
        end
        send_word(OP_MAP, '0, '1);

        // Shrinking the count keeps every loaded id in the emit run.
        set_count(CFG_W'(2));
        send_word(OP_EMIT, '0, '0);
        send_word(OP_LOAD, 32'sd7, '0);
        send_word(OP_CLEAR, $urandom, LABEL_W'($urandom));
        send_word(OP_EMIT, '0, '0);
        send_word(OP_MAP, '0, '0);

        drain();
        write_reg(SPARE_ADDR, CFG_W'($urandom));
        read_count();
        set_count(CFG_W'(0));
        send_word(OP_LOAD, '1, '0);
        send_word(OP_LOAD, '0, '0);
        send_word(OP_MAP, '0, '0);
        send_word(OP_EMIT, '0, '0);

        words_sent = 0;
        session = 0;
        while (words_sent < RANDOM_WORDS) begin
            set_count(CFG_W'(session < 6 ? cfg_list[session] : $urandom_range(0, 31)));
            case (session % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            if ($urandom_range(0, 99) < 80) begin
                send_word(OP_CLEAR, $urandom, LABEL_W'($urandom));
            end
            loads = $urandom_range(0, remap_board.active_count() + 2);
            kmode = $urandom_range(0, 2);
            for (int i = 0; i < loads; i++) begin
                send_word(OP_LOAD, pick_key(kmode), LABEL_W'($urandom));
            end
            send_word(OP_EMIT, $urandom, LABEL_W'($urandom));
            live = (loads < remap_board.active_count()) ? loads : remap_board.active_count();
            maps = $urandom_range(2, 8);
            for (int i = 0; i < maps; i++) begin
                if (live > 0 && $urandom_range(0, 99) < 75) begin
                    send_word(OP_MAP, $urandom, LABEL_W'($urandom_range(0, live - 1)));
                end else begin
                    send_word(OP_MAP, $urandom, LABEL_W'($urandom));
                end
            end
            repeat ($urandom_range(0, 3)) begin
                send_word(opcode_t'($urandom_range(0, 3)), $urandom, LABEL_W'($urandom));
            end
            if ($urandom_range(0, 1) == 1) begin
                send_word(OP_EMIT, $urandom, LABEL_W'($urandom));
            end
            session++;
        end

        drain();
        if (remap_board.errors == 0) begin
            $display("cluster_label_rank_remap_core test passed");
        end else begin
            $display("cluster_label_rank_remap_core test failed");
        end
        $finish;
    end

endmodule
